>>> rtl/sdf_pkg.sv
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 2;
  localparam int DIFF_W = DATA_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ROOT_W = DIFF_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = 64;
  localparam int PROD_W = NUM_W + DIFF_W;
  localparam int SUM_W  = 66;

  localparam logic [IDX_W-1:0] REG_REST_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_STIFFNESS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DAMPING     = 2'd2;

  localparam logic [CFG_W-1:0] REST_LENGTH_RST = 31'd65536;
  localparam logic [CFG_W-1:0] STIFFNESS_RST   = 31'd65536;
  localparam logic [CFG_W-1:0] DAMPING_RST     = 31'd0;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic [2:0]             dvneg;
    logic [2:0][NUM_W-1:0]  dmp;
  } sq_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] dmp;
    logic             dvneg;
    logic             sneg;
    logic             zr;
  } div_side_t;

endpackage

>>> rtl/sdf_isqrt.sv
`timescale 1ns / 1ps
module sdf_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [sdf_pkg::SQ_W-1:0]   sq,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [sdf_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int STEPS = sdf_pkg::ROOT_W;
  localparam int SQ_W  = sdf_pkg::SQ_W;
  localparam int RT_W  = sdf_pkg::ROOT_W;
  localparam int RM_W  = sdf_pkg::REM_W;

  logic [SQ_W-1:0]   s_q  [STEPS];
  logic [RT_W-1:0]   rt_q [STEPS];
  logic [RM_W-1:0]   rm_q [STEPS];
  logic [SIDE_W-1:0] sd_q [STEPS];
  logic [STEPS-1:0]  v_q;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic [SQ_W-1:0]   s_in;
    logic [RT_W-1:0]   rt_in;
    logic [RM_W-1:0]   rm_in;
    logic [SIDE_W-1:0] sd_in;
    logic              v_in;
    logic [RM_W+1:0]   cand;
    logic [RM_W+1:0]   trial;
    logic [RM_W+1:0]   diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign s_in  = sq;
      assign rt_in = '0;
      assign rm_in = '0;
      assign sd_in = in_side;
      assign v_in  = in_valid;
    end else begin : g_next
      assign s_in  = s_q[g-1];
      assign rt_in = rt_q[g-1];
      assign rm_in = rm_q[g-1];
      assign sd_in = sd_q[g-1];
      assign v_in  = v_q[g-1];
    end

    assign cand  = {rm_in, s_in[SQ_W-1 -: 2]};
    assign trial = {{(RM_W-RT_W){1'b0}}, rt_in, 2'b01};
    assign ge    = cand >= trial;
    assign diff  = cand - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[g] <= 1'b0;
      end else if (adv) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_q[g]  <= {s_in[SQ_W-3:0], 2'b00};
        rt_q[g] <= {rt_in[RT_W-2:0], ge};
        rm_q[g] <= ge ? diff[RM_W-1:0] : cand[RM_W-1:0];
        sd_q[g] <= sd_in;
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign root      = rt_q[STEPS-1];
  assign out_side  = sd_q[STEPS-1];

endmodule

>>> rtl/sdf_div.sv
`timescale 1ns / 1ps
module sdf_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [sdf_pkg::PROD_W-1:0] num,
  input  logic [sdf_pkg::ROOT_W-1:0] den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [sdf_pkg::NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int STEPS = sdf_pkg::NUM_W;
  localparam int D_W   = sdf_pkg::ROOT_W;

  logic [D_W-1:0]    rm_q [STEPS];
  logic [STEPS-1:0]  lq_q [STEPS];
  logic [D_W-1:0]    dn_q [STEPS];
  logic [SIDE_W-1:0] sd_q [STEPS];
  logic [STEPS-1:0]  v_q;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic [D_W-1:0]    rm_in;
    logic [STEPS-1:0]  lq_in;
    logic [D_W-1:0]    dn_in;
    logic [SIDE_W-1:0] sd_in;
    logic              v_in;
    logic [D_W:0]      t;
    logic [D_W:0]      diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign rm_in = num[sdf_pkg::PROD_W-1 -: D_W];
      assign lq_in = num[STEPS-1:0];
      assign dn_in = den;
      assign sd_in = in_side;
      assign v_in  = in_valid;
    end else begin : g_next
      assign rm_in = rm_q[g-1];
      assign lq_in = lq_q[g-1];
      assign dn_in = dn_q[g-1];
      assign sd_in = sd_q[g-1];
      assign v_in  = v_q[g-1];
    end

    assign t    = {rm_in, lq_in[STEPS-1]};
    assign ge   = t >= {1'b0, dn_in};
    assign diff = t - {1'b0, dn_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[g] <= 1'b0;
      end else if (adv) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rm_q[g] <= ge ? diff[D_W-1:0] : t[D_W-1:0];
        lq_q[g] <= {lq_in[STEPS-2:0], ge};
        dn_q[g] <= dn_in;
        sd_q[g] <= sd_in;
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign quo       = lq_q[STEPS-1];
  assign out_side  = sd_q[STEPS-1];

endmodule

>>> rtl/spring_damper_force.sv
`timescale 1ns / 1ps
// spring-damper force on mass A: F = -k*(r-L)*d/r - c*(vA-vB), d = posA-posB, r = |d|,
// spring term dropped when r is zero; mass B gets -F. all values signed fixed point with
// FRAC_BITS fraction bits, each force component saturated to 32 bits, both terms truncated
// toward zero. fully pipelined: one beat accepted per cycle while the output is not stalled,
// with a register stage per digit in the 33-digit square root and in the 64-step restoring
// divide. a stalled output freezes the whole pipeline.
module spring_damper_force #(
  parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sdf_pkg::IDX_W-1:0]        cfg_index,
  input  logic [sdf_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [sdf_pkg::DATA_W-1:0] pos_a_x,
  input  logic signed [sdf_pkg::DATA_W-1:0] pos_a_y,
  input  logic signed [sdf_pkg::DATA_W-1:0] pos_a_z,
  input  logic signed [sdf_pkg::DATA_W-1:0] pos_b_x,
  input  logic signed [sdf_pkg::DATA_W-1:0] pos_b_y,
  input  logic signed [sdf_pkg::DATA_W-1:0] pos_b_z,
  input  logic signed [sdf_pkg::DATA_W-1:0] vel_a_x,
  input  logic signed [sdf_pkg::DATA_W-1:0] vel_a_y,
  input  logic signed [sdf_pkg::DATA_W-1:0] vel_a_z,
  input  logic signed [sdf_pkg::DATA_W-1:0] vel_b_x,
  input  logic signed [sdf_pkg::DATA_W-1:0] vel_b_y,
  input  logic signed [sdf_pkg::DATA_W-1:0] vel_b_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sdf_pkg::DATA_W-1:0] force_x,
  output logic signed [sdf_pkg::DATA_W-1:0] force_y,
  output logic signed [sdf_pkg::DATA_W-1:0] force_z
);

  localparam int DW  = sdf_pkg::DATA_W;
  localparam int CW  = sdf_pkg::CFG_W;
  localparam int XW  = sdf_pkg::DIFF_W;
  localparam int SW  = sdf_pkg::SQ_W;
  localparam int RW  = sdf_pkg::ROOT_W;
  localparam int NW  = sdf_pkg::NUM_W;
  localparam int PW  = sdf_pkg::PROD_W;
  localparam int TW  = sdf_pkg::SUM_W;
  localparam int SQ_SIDE_W  = $bits(sdf_pkg::sq_side_t);
  localparam int DIV_SIDE_W = $bits(sdf_pkg::div_side_t);

  logic [CW-1:0] rest_length;
  logic [CW-1:0] stiffness;
  logic [CW-1:0] damping;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length <= sdf_pkg::REST_LENGTH_RST;
      stiffness   <= sdf_pkg::STIFFNESS_RST;
      damping     <= sdf_pkg::DAMPING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdf_pkg::REG_REST_LENGTH: rest_length <= cfg_data;
        sdf_pkg::REG_STIFFNESS:   stiffness   <= cfg_data;
        sdf_pkg::REG_DAMPING:     damping     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = rst || !adv;

  logic signed [DW-1:0] pa [3];
  logic signed [DW-1:0] pb [3];
  logic signed [DW-1:0] va [3];
  logic signed [DW-1:0] vb [3];
  assign pa = '{pos_a_x, pos_a_y, pos_a_z};
  assign pb = '{pos_b_x, pos_b_y, pos_b_z};
  assign va = '{vel_a_x, vel_a_y, vel_a_z};
  assign vb = '{vel_b_x, vel_b_y, vel_b_z};

  // stage 0: differences
  logic          v0;
  logic [XW-1:0] d0  [3];
  logic [XW-1:0] dv0 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d0[i]  <= {pa[i][DW-1], pa[i]} - {pb[i][DW-1], pb[i]};
        dv0[i] <= {va[i][DW-1], va[i]} - {vb[i][DW-1], vb[i]};
      end
    end
  end

  // stage 1: magnitudes, squares, damping product
  logic          v1;
  logic [XW-1:0] dmag1 [3];
  logic [2:0]    dneg1;
  logic [2:0]    dvneg1;
  logic [2*DW-1:0] sqlo1 [3];
  logic [2:0]    sqhi1;
  logic [DW+CW-1:0] cp1 [3];
  logic [2:0]    dvh1;
  logic [XW-1:0] dm0  [3];
  logic [XW-1:0] dvm0 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm0[i]  = d0[i][XW-1] ? (~d0[i] + 1'b1) : d0[i];
      dvm0[i] = dv0[i][XW-1] ? (~dv0[i] + 1'b1) : dv0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dmag1[i]  <= dm0[i];
        dneg1[i]  <= d0[i][XW-1];
        dvneg1[i] <= dv0[i][XW-1];
        sqlo1[i]  <= dm0[i][DW-1:0] * dm0[i][DW-1:0];
        sqhi1[i]  <= dm0[i][DW];
        cp1[i]    <= damping * dvm0[i][DW-1:0];
        dvh1[i]   <= dvm0[i][DW];
      end
    end
  end

  // stage 2: sum of squares, damping magnitude
  logic            v2;
  logic [SW-1:0]   ssum2;
  sdf_pkg::sq_side_t side2;
  logic [SW-1:0]   sqt [3];
  logic [NW-1:0]   dfull [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqt[i]   = sqhi1[i] ? {2'b01, {(SW-2){1'b0}}} : {2'b00, sqlo1[i]};
      dfull[i] = {1'b0, cp1[i]} + (dvh1[i] ? {1'b0, damping, {DW{1'b0}}} : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ssum2 <= sqt[0] + sqt[1] + sqt[2];
      for (int i = 0; i < 3; i++) begin
        side2.dmag[i] <= dmag1[i];
        side2.dmp[i]  <= dfull[i] >> FRAC_BITS;
      end
      side2.dneg  <= dneg1;
      side2.dvneg <= dvneg1;
    end
  end

  // square root
  logic              vr;
  logic [RW-1:0]     r_s;
  sdf_pkg::sq_side_t sider;

  sdf_isqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v2),
    .sq        (ssum2),
    .in_side   (side2),
    .out_valid (vr),
    .root      (r_s),
    .out_side  (sider)
  );

  // stage 3: extension r - L
  logic              v3;
  logic [RW-1:0]     r3;
  logic [XW-1:0]     emag3;
  logic              eneg3;
  logic              zr3;
  sdf_pkg::sq_side_t side3;
  logic [RW:0]       e_c;

  assign e_c = {1'b0, r_s} - {{(RW+1-CW){1'b0}}, rest_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3    <= r_s;
      eneg3 <= e_c[RW];
      emag3 <= e_c[RW] ? XW'(~e_c + 1'b1) : e_c[XW-1:0];
      zr3   <= (r_s == '0);
      side3 <= sider;
    end
  end

  // stage 4: k * |e| low part
  logic              v4;
  logic [RW-1:0]     r4;
  logic [DW+CW-1:0]  kel4;
  logic              eh4;
  logic              eneg4;
  logic              zr4;
  sdf_pkg::sq_side_t side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4    <= r3;
      kel4  <= stiffness * emag3[DW-1:0];
      eh4   <= emag3[DW];
      eneg4 <= eneg3;
      zr4   <= zr3;
      side4 <= side3;
    end
  end

  // stage 5: k * |e|
  logic              v5;
  logic [RW-1:0]     r5;
  logic [NW-1:0]     num5;
  logic              eneg5;
  logic              zr5;
  sdf_pkg::sq_side_t side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r5    <= r4;
      num5  <= {1'b0, kel4} + (eh4 ? {1'b0, stiffness, {DW{1'b0}}} : '0);
      eneg5 <= eneg4;
      zr5   <= zr4;
      side5 <= side4;
    end
  end

  // stage 6: partial products of num * |d_i|
  logic              v6;
  logic [RW-1:0]     r6;
  logic [NW-1:0]     num6;
  logic [2*DW-1:0]   p0_6 [3];
  logic [2*DW-1:0]   p1_6 [3];
  logic [2:0]        dh6;
  logic              eneg6;
  logic              zr6;
  sdf_pkg::sq_side_t side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r6    <= r5;
      num6  <= num5;
      for (int i = 0; i < 3; i++) begin
        p0_6[i] <= num5[DW-1:0] * side5.dmag[i][DW-1:0];
        p1_6[i] <= num5[NW-1:DW] * side5.dmag[i][DW-1:0];
        dh6[i]  <= side5.dmag[i][DW];
      end
      eneg6 <= eneg5;
      zr6   <= zr5;
      side6 <= side5;
    end
  end

  // stage 7: full dividend
  logic                v7;
  logic [RW-1:0]       r7;
  logic [PW-1:0]       prod7 [3];
  sdf_pkg::div_side_t  dside7 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r7 <= r6;
      for (int i = 0; i < 3; i++) begin
        prod7[i] <= {{(PW-2*DW){1'b0}}, p0_6[i]}
                  + {{(PW-3*DW){1'b0}}, p1_6[i], {DW{1'b0}}}
                  + (dh6[i] ? {{(PW-NW-DW){1'b0}}, num6, {DW{1'b0}}} : '0);
        dside7[i].dmp   <= side6.dmp[i];
        dside7[i].dvneg <= side6.dvneg[i];
        dside7[i].sneg  <= eneg6 ^ side6.dneg[i];
        dside7[i].zr    <= zr6;
      end
    end
  end

  // divide by r, one lane per axis
  logic [2:0]         vq;
  logic [NW-1:0]      q_s   [3];
  sdf_pkg::div_side_t dsideq [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sdf_div #(
      .SIDE_W (DIV_SIDE_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (v7),
      .num       (prod7[g]),
      .den       (r7),
      .in_side   (dside7[g]),
      .out_valid (vq[g]),
      .quo       (q_s[g]),
      .out_side  (dsideq[g])
    );
  end

  // output stage: combine and saturate
  logic signed [TW-1:0] tot [3];
  logic signed [DW-1:0] sat [3];
  logic [NW-1:0]        spr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      spr[i] = q_s[i] >> FRAC_BITS;
      tot[i] = dsideq[i].dvneg ? signed'({2'b00, dsideq[i].dmp})
                               : -signed'({2'b00, dsideq[i].dmp});
      if (!dsideq[i].zr) begin
        tot[i] = dsideq[i].sneg ? tot[i] + signed'({2'b00, spr[i]})
                                : tot[i] - signed'({2'b00, spr[i]});
      end
      if (tot[i] > signed'(TW'({1'b0, {(DW-1){1'b1}}}))) begin
        sat[i] = {1'b0, {(DW-1){1'b1}}};
      end else if (tot[i] < -signed'(TW'({1'b1, {(DW-1){1'b0}}}))) begin
        sat[i] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        sat[i] = tot[i][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= &vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      force_x <= sat[0];
      force_y <= sat[1];
      force_z <= sat[2];
    end
  end

endmodule
